// File: hw/rtl/gctb_pkg.sv
// Shared types, codes and constants for the busy-time token bucket.
package gctb_pkg;

    localparam int TS_W     = 64;
    localparam int WEIGHT_W = 8;
    localparam int PROD_W   = TS_W + WEIGHT_W;
    localparam int IDX_W    = 2;

    localparam logic [TS_W-1:0]     LEVEL_MAX         = {TS_W{1'b1}};
    localparam logic [TS_W-1:0]     EXCESS_THR_RESET  = 64'd30_000_000_000;
    localparam logic [WEIGHT_W-1:0] IDLE_WEIGHT_RESET = 8'd5;
    localparam logic [TS_W-1:0]     WARN_THR_RESET    = {TS_W{1'b1}};

    // event kinds
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_EXCESS_THR  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IDLE_WEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_WARN_THR    = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_NONE   = 2'd0,
        VERDICT_WARN   = 2'd1,
        VERDICT_EXCESS = 2'd2
    } t_verdict;

    // measured interval, leaving the front stage
    typedef struct packed {
        logic            action;
        logic [TS_W-1:0] span;
    } t_span_item;

    // amount to add to or drain from the bucket
    typedef struct packed {
        logic            action;
        logic [TS_W-1:0] delta;
    } t_delta_item;

endpackage

// File: hw/rtl/gctb_span.sv
// Front stage: event timestamps and interval measurement.
module gctb_span (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic [63:0]             i_timestamp_ns,
    output logic                    o_valid,
    input  logic                    i_ready,
    output gctb_pkg::t_span_item    o_item
);
    import gctb_pkg::*;

    logic            r_valid;
    t_span_item      r_item;
    logic [TS_W-1:0] r_began_at;
    logic [TS_W-1:0] r_ended_at;
    logic [TS_W-1:0] w_from;
    logic [TS_W-1:0] w_span;
    logic            w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // start measures idle time from last finish, finish measures busy time
    assign w_from = (i_action == ACT_FINISH) ? r_began_at : r_ended_at;
    // time going backwards counts as zero
    assign w_span = (i_timestamp_ns >= w_from) ? (i_timestamp_ns - w_from) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_began_at <= '0;
            r_ended_at <= '0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                if (i_action == ACT_FINISH) begin
                    r_ended_at <= i_timestamp_ns;
                end else begin
                    r_began_at <= i_timestamp_ns;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action <= i_action;
            r_item.span   <= w_span;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/gctb_drain.sv
// Middle stage: weights idle time into a saturated drain amount; busy time passes unchanged.
module gctb_drain (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [7:0]              i_idle_weight,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  gctb_pkg::t_span_item    i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output gctb_pkg::t_delta_item   o_item
);
    import gctb_pkg::*;

    logic              r_valid;
    t_delta_item       r_item;
    logic [PROD_W-1:0] w_prod;
    logic [TS_W-1:0]   w_drain;
    logic [TS_W-1:0]   w_delta;
    logic              w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_prod  = {{WEIGHT_W{1'b0}}, i_item.span} * {{TS_W{1'b0}}, i_idle_weight};
    assign w_drain = (|w_prod[PROD_W-1:TS_W]) ? LEVEL_MAX : w_prod[TS_W-1:0];
    assign w_delta = (i_item.action == ACT_FINISH) ? i_item.span : w_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action <= i_item.action;
            r_item.delta  <= w_delta;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/gctb_bucket.sv
// Final stage: bucket level, threshold checks and the result register.
module gctb_bucket (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [63:0]             i_excess_thr,
    input  logic [63:0]             i_warn_thr,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  gctb_pkg::t_delta_item   i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [63:0]             o_bucket_level,
    output logic [1:0]              o_verdict,
    output logic                    o_tripped
);
    import gctb_pkg::*;

    logic            r_valid;
    logic [TS_W-1:0] r_bucket;
    logic            r_latched;
    logic [TS_W-1:0] r_level;
    t_verdict        r_verdict;
    logic            r_tripped;

    logic [TS_W:0]   w_sum;
    logic [TS_W-1:0] n_bucket;
    t_verdict        n_verdict;
    logic            n_latched;
    logic            w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_sum = {1'b0, r_bucket} + {1'b0, i_item.delta};

    always_comb begin
        n_bucket  = r_bucket;
        n_verdict = VERDICT_NONE;
        n_latched = r_latched;
        if (i_item.action == ACT_FINISH) begin
            n_bucket = w_sum[TS_W] ? LEVEL_MAX : w_sum[TS_W-1:0];
            priority if (n_bucket > i_excess_thr) begin
                n_verdict = VERDICT_EXCESS;
                n_latched = 1'b1;
            end else if (n_bucket > i_warn_thr) begin
                n_verdict = VERDICT_WARN;
            end else begin
                n_verdict = VERDICT_NONE;
            end
        end else begin
            // drain floors at zero
            n_bucket = (i_item.delta > r_bucket) ? '0 : (r_bucket - i_item.delta);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_bucket  <= '0;
            r_latched <= 1'b0;
        end else if (w_accept) begin
            r_valid   <= 1'b1;
            r_bucket  <= n_bucket;
            r_latched <= n_latched;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_level   <= n_bucket;
            r_verdict <= n_verdict;
            r_tripped <= n_latched;
        end
    end

    assign o_valid        = r_valid;
    assign o_bucket_level = r_level;
    assign o_verdict      = r_verdict;
    assign o_tripped      = r_tripped;

endmodule

// File: hw/rtl/gc_time_token_bucket.sv
// Busy-time token bucket limiter: top level with configuration registers.
// Takes one start/finish event per cycle while the pipeline is not stalled and
// returns one result per event through three registered stages. Stage one
// measures the interval against the stored start/finish timestamps, stage two
// applies the 64x8 saturating idle-weight multiply, stage three updates the
// bucket and checks the thresholds; the bucket register feeding back into
// its own add/subtract is the one loop and sets the one-event-per-cycle rate.
// Each stage holds its data only while the stage after it is full and
// stalled, so bubbles close up. Configuration writes take effect at once and
// are meant to be made while no event is in flight.
module gc_time_token_bucket (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [63:0] i_timestamp_ns,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_bucket_level,
    output logic [1:0]  o_verdict,
    output logic        o_tripped
);
    import gctb_pkg::*;

    logic [TS_W-1:0]     r_excess_thr;
    logic [WEIGHT_W-1:0] r_idle_weight;
    logic [TS_W-1:0]     r_warn_thr;

    logic        w_span_valid;
    logic        w_span_ready;
    t_span_item  w_span_item;
    logic        w_delta_valid;
    logic        w_delta_ready;
    t_delta_item w_delta_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excess_thr  <= EXCESS_THR_RESET;
            r_idle_weight <= IDLE_WEIGHT_RESET;
            r_warn_thr    <= WARN_THR_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_EXCESS_THR:  r_excess_thr  <= i_cfg_wdata;
                REG_IDLE_WEIGHT: r_idle_weight <= i_cfg_wdata[WEIGHT_W-1:0];
                REG_WARN_THR:    r_warn_thr    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    gctb_span u_span (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_timestamp_ns (i_timestamp_ns),
        .o_valid        (w_span_valid),
        .i_ready        (w_span_ready),
        .o_item         (w_span_item)
    );

    gctb_drain u_drain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_idle_weight (r_idle_weight),
        .i_valid       (w_span_valid),
        .o_ready       (w_span_ready),
        .i_item        (w_span_item),
        .o_valid       (w_delta_valid),
        .i_ready       (w_delta_ready),
        .o_item        (w_delta_item)
    );

    gctb_bucket u_bucket (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_excess_thr   (r_excess_thr),
        .i_warn_thr     (r_warn_thr),
        .i_valid        (w_delta_valid),
        .o_ready        (w_delta_ready),
        .i_item         (w_delta_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bucket_level (o_bucket_level),
        .o_verdict      (o_verdict),
        .o_tripped      (o_tripped)
    );

endmodule

// File: hw/rtl/gctb_checker.sv
// Port-level checks for the busy-time token bucket, bound to the top level.
module gctb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [63:0] o_bucket_level,
    input  logic [1:0]  o_verdict,
    input  logic        o_tripped
);
    import gctb_pkg::*;

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // an excessive verdict always shows the sticky flag
    a_excess_trips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict == VERDICT_EXCESS) |-> o_tripped)
        else $error("excessive verdict without tripped flag");

    // a threshold can only be passed by a nonempty bucket
    a_verdict_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict != VERDICT_NONE) |-> (o_bucket_level != '0))
        else $error("verdict raised on an empty bucket");

    // tripped never clears until reset
    a_tripped_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_tripped) ##1 (o_valid && $past(i_rst_n))
            |-> o_tripped)
        else $error("tripped flag cleared");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_bucket_level)
            && $stable(o_verdict) && $stable(o_tripped)))
        else $error("stalled result changed");

endmodule

bind gc_time_token_bucket gctb_checker u_gctb_checker (.*);
